@@ hdl/evicting_drop_tracker_macros.svh @@
// Assertion macros for the drop tracker.
`ifndef EVICTING_DROP_TRACKER_MACROS_SVH
`define EVICTING_DROP_TRACKER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define EDT_ASSERT_IMP(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("check failed");
// Next-cycle implication checked outside reset.
`define EDT_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("check failed");
`endif

@@ hdl/edt_pkg.sv @@
// Types and codes used by the drop tracker top level.
package edt_pkg;
   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_EXTRACT = 2'd1;
   localparam logic [1:0] ACT_RESTORE = 2'd2;

   localparam logic [2:0] ST_STORED    = 3'd0;
   localparam logic [2:0] ST_EVICTED   = 3'd1;
   localparam logic [2:0] ST_DROPPED   = 3'd2;
   localparam logic [2:0] ST_EXTRACTED = 3'd3;
   localparam logic [2:0] ST_NOMATCH   = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] rel_id;
      logic [31:0] db_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] result_rel_id;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_OUT
   } state_type;
endpackage

@@ hdl/edt_if.sv @@
// Valid/ready channel interface carrying one payload.
interface edt_if #(type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/evicting_drop_tracker.sv @@
// Top level of the drop tracker: age-ordered slot list with a walking sequencer.
// Add: reads the target slot, then registers the result; restore: no read; one request at a time.
// Extract: walks the list newest to oldest, reading each stored entry in S_READ and S_CHECK;
// a match is sent when the next one is found, the final one after the walk ends.
// Each entry is read through the single read port of the slot memory; a held result stalls the walk.
// Synchronous active-high reset empties the list; slot contents are not cleared.
`include "evicting_drop_tracker_macros.svh"
module evicting_drop_tracker #(
   parameter int CAPACITY = 32
) (
   input logic clock,
   input logic reset,
   edt_if.sink   req,
   edt_if.source rsp
);
   import edt_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic [31:0]   rel_mem   [CAPACITY];
   logic [31:0]   db_mem    [CAPACITY];
   logic [IW-1:0] newer_mem [CAPACITY];
   logic [IW-1:0] older_mem [CAPACITY];

   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [IW-1:0] oldest_ff, oldest_in, newest_ff, newest_in;
   logic [CW-1:0] used_ff, used_in;
   state_type     state_ff, state_in;
   req_type       cur_ff, cur_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic          hit_ff, hit_in;
   rsp_type       out_ff, out_in;
   logic          ovalid_ff, ovalid_in;

   logic [31:0]   rd_rel, rd_db;
   logic [IW-1:0] rd_newer, rd_older;

   logic [IW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_slot = IW'(i);
      end
   end

   // memory write port
   logic          we_data;
   logic [IW-1:0] wa_data;
   logic          we_n, we_o;
   logic [IW-1:0] wa_n, wd_n, wa_o, wd_o;

   always_ff @(posedge clock) begin
      if (we_data) begin
         rel_mem[wa_data] <= cur_ff.rel_id;
         db_mem[wa_data]  <= cur_ff.db_id;
      end
      if (we_n) newer_mem[wa_n] <= wd_n;
      if (we_o) older_mem[wa_o] <= wd_o;
      rd_rel   <= rel_mem[slot_in];
      rd_db    <= db_mem[slot_in];
      rd_newer <= newer_mem[slot_in];
      rd_older <= older_mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         oldest_ff <= '0;
         newest_ff <= '0;
         used_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         used_ff   <= used_in;
         ovalid_ff <= ovalid_in;
      end
      cur_ff  <= cur_in;
      slot_ff <= slot_in;
      walk_ff <= walk_in;
      hit_ff  <= hit_in;
      out_ff  <= out_in;
   end

   assign req.ready   = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp.valid   = ovalid_ff;
   assign rsp.payload = out_ff;

   logic drop_now;
   logic is_old, is_new;

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      used_in   = used_ff;
      cur_in    = cur_ff;
      slot_in   = slot_ff;
      walk_in   = walk_ff;
      hit_in    = hit_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      we_data = 1'b0; wa_data = slot_ff;
      we_n = 1'b0; wa_n = '0; wd_n = '0;
      we_o = 1'b0; wa_o = '0; wd_o = '0;
      drop_now = 1'b0;
      is_old = (slot_ff == oldest_ff);
      is_new = (slot_ff == newest_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cur_in = req.payload;
               hit_in = 1'b0;
               walk_in = '0;
               unique case (req.payload.action)
                  ACT_ADD: begin
                     slot_in = (used_ff >= CAP) ? oldest_ff : free_slot;
                     state_in = S_READ;
                  end
                  ACT_EXTRACT: begin
                     slot_in = newest_ff;
                     walk_in = used_ff;
                     state_in = (used_ff == '0) ? S_OUT : S_READ;
                  end
                  ACT_RESTORE: begin
                     slot_in = free_slot;
                     state_in = S_OUT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            // read data for slot_ff arrives next cycle
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cur_ff.action == ACT_ADD) begin
               if (used_ff >= CAP) begin
                  // evict oldest and reuse its slot as newest
                  if (!is_new) oldest_in = rd_newer;
                  we_data = 1'b1;
                  we_n = !is_new; wa_n = newest_ff; wd_n = slot_ff;
                  we_o = !is_new; wa_o = slot_ff; wd_o = is_new ? rd_older : newest_ff;
                  newest_in = slot_ff;
                  out_in = '{ST_EVICTED, rd_rel, 1'b1};
               end else begin
                  we_data = 1'b1;
                  if (used_ff == '0) begin
                     oldest_in = slot_ff;
                  end else begin
                     we_n = 1'b1; wa_n = newest_ff; wd_n = slot_ff;
                     we_o = 1'b1; wa_o = slot_ff; wd_o = newest_ff;
                  end
                  newest_in = slot_ff;
                  valid_in[slot_ff] = 1'b1;
                  used_in = used_ff + 1'b1;
                  out_in = '{ST_STORED, 32'd0, 1'b1};
               end
               ovalid_in = 1'b1;
               state_in = S_IDLE;
            end else if (!ovalid_ff || rsp.ready) begin
               walk_in = walk_ff - 1'b1;
               drop_now = (rd_db == cur_ff.db_id);
               if (drop_now) begin
                  if (is_old && is_new) begin
                  end else if (is_old) begin
                     oldest_in = rd_newer;
                  end else if (is_new) begin
                     newest_in = rd_older;
                  end else begin
                     we_n = 1'b1; wa_n = rd_older; wd_n = rd_newer;
                     we_o = 1'b1; wa_o = rd_newer; wd_o = rd_older;
                  end
                  valid_in[slot_ff] = 1'b0;
                  used_in = used_ff - 1'b1;
                  // send the previous match, hold this one
                  if (hit_ff) begin
                     out_in = '{ST_EXTRACTED, cur_ff.rel_id, 1'b0};
                     ovalid_in = 1'b1;
                  end
                  cur_in.rel_id = rd_rel;
                  hit_in = 1'b1;
               end
               slot_in = rd_older;
               state_in = (walk_in == '0) ? S_OUT : S_READ;
            end
         end
         S_OUT: begin
            if (!ovalid_ff || rsp.ready) begin
               if (cur_ff.action == ACT_RESTORE) begin
                  if (used_ff >= CAP) begin
                     out_in = '{ST_DROPPED, 32'd0, 1'b1};
                  end else begin
                     we_data = 1'b1;
                     if (used_ff == '0) begin
                        newest_in = slot_ff;
                     end else begin
                        we_o = 1'b1; wa_o = oldest_ff; wd_o = slot_ff;
                        we_n = 1'b1; wa_n = slot_ff; wd_n = oldest_ff;
                     end
                     oldest_in = slot_ff;
                     valid_in[slot_ff] = 1'b1;
                     used_in = used_ff + 1'b1;
                     out_in = '{ST_STORED, 32'd0, 1'b1};
                  end
               end else if (hit_ff) begin
                  out_in = '{ST_EXTRACTED, cur_ff.rel_id, 1'b1};
               end else begin
                  out_in = '{ST_NOMATCH, 32'd0, 1'b1};
               end
               ovalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `EDT_ASSERT_IMP(a_ready_idle, req.ready, state_ff == S_IDLE)
   `EDT_ASSERT_IMP(a_used_cap, 1'b1, used_ff <= CAP)
   `EDT_ASSERT_NEXT(a_hold_out, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload))
endmodule
